// File: rtl/core/tnrd_pkg.sv
// ----------------------------------------------------------------------------
// tnrd_pkg
// Shared codes, types and helpers for the telnet receive deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tnrd_pkg;

  // Telnet protocol bytes
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_NAWS = 8'd31;

  // Bytes between the option and SE for a well-formed window size update
  localparam logic [2:0] NAWS_LEN  = 3'd5;
  localparam logic [2:0] SUB_SAT   = 3'd7;
  localparam logic [2:0] SUB_SLOTS = 3'd4;

  // Default queue depths
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_OPT   = 2'd1,
    KIND_CMD   = 2'd2,
    KIND_WINSZ = 2'd3
  } kind_t;

  // Option verbs
  typedef enum logic [1:0] {
    VERB_DO   = 2'd0,
    VERB_DONT = 2'd1,
    VERB_WILL = 2'd2,
    VERB_WONT = 2'd3
  } verb_t;

  // Byte classes found by the front end
  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_IAC   = 3'd1,
    CLS_SB    = 3'd2,
    CLS_VERB  = 3'd3,
    CLS_SE    = 3'd4
  } cls_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    verb_t      verb;
    logic       is_naws;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // One result transfer
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value_byte;
    verb_t       verb;
    logic [15:0] window_width;
    logic [15:0] window_height;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // Verb code of a DO/DONT/WILL/WONT byte
  function automatic verb_t verb_of(input logic [7:0] b);
    verb_t v;
    v = VERB_DO;
    unique case (b)
      TN_DONT: v = VERB_DONT;
      TN_WILL: v = VERB_WILL;
      TN_WONT: v = VERB_WONT;
      default: v = VERB_DO;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tnrd_fifo.sv
// ----------------------------------------------------------------------------
// tnrd_fifo
// Small flip-flop queue, first-word fall-through, push when not full.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [Width-1:0]  wdata,
  output logic             full,
  input  wire              pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tnrd_front.sv
// ----------------------------------------------------------------------------
// tnrd_front
// Byte classifier: tags each received byte for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrd_front (
  input  wire  [7:0]          rx_byte,
  output tnrd_pkg::item_t     item
);

  import tnrd_pkg::*;

  cls_t cls;

  always_comb begin
    unique case (rx_byte) inside
      TN_IAC:                           cls = CLS_IAC;
      TN_SB:                            cls = CLS_SB;
      TN_SE:                            cls = CLS_SE;
      TN_DO, TN_DONT, TN_WILL, TN_WONT: cls = CLS_VERB;
      default:                          cls = CLS_OTHER;
    endcase
  end

  // data, class, verb code, NAWS flag
  assign item = {rx_byte, cls, verb_of(rx_byte), (rx_byte == TN_NAWS)};

endmodule

`default_nettype wire

// File: rtl/core/tnrd_parser.sv
// ----------------------------------------------------------------------------
// tnrd_parser
// Telnet sequence state machine; turns classified bytes into results.
// ----------------------------------------------------------------------------
`default_nettype none

module tnrd_parser (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  tnrd_pkg::item_t     in_item,
  output logic                in_take,
  input  wire                 res_full,
  output logic                res_push,
  output tnrd_pkg::result_t   res
);

  import tnrd_pkg::*;

  typedef enum logic [4:0] {
    PH_DATA   = 5'b00001,
    PH_IAC    = 5'b00010,
    PH_OPTION = 5'b00100,
    PH_SBOPT  = 5'b01000,
    PH_SBDATA = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  verb_t       pending_verb, pending_verb_next;
  logic        sub_naws, sub_naws_next;
  logic [2:0]  sub_count, sub_count_next;
  logic [7:0]  sub_bytes [4];
  logic        sub_wr;
  logic        emit;

  // a byte without a result never waits for room in the result queue
  assign in_take  = in_valid && (!res_full || !emit);
  assign res_push = in_take && emit;

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    sub_naws_next     = sub_naws;
    sub_count_next    = sub_count;
    sub_wr            = 1'b0;
    emit              = 1'b0;
    res               = '0;
    res.value_byte    = in_item.data;
    unique case (phase)
      PH_IAC: begin
        phase_next = PH_DATA;
        unique case (in_item.cls)
          CLS_IAC: begin
            emit     = 1'b1;
            res.kind = KIND_DATA;
          end
          CLS_SB: phase_next = PH_SBOPT;
          CLS_VERB: begin
            pending_verb_next = in_item.verb;
            phase_next        = PH_OPTION;
          end
          default: begin
            emit     = 1'b1;
            res.kind = KIND_CMD;
          end
        endcase
      end
      PH_OPTION: begin
        phase_next = PH_DATA;
        emit       = 1'b1;
        res.kind   = KIND_OPT;
        res.verb   = pending_verb;
      end
      PH_SBOPT: begin
        sub_naws_next  = in_item.is_naws;
        sub_count_next = '0;
        phase_next     = PH_SBDATA;
      end
      PH_SBDATA: begin
        if (in_item.cls == CLS_SE) begin
          phase_next = PH_DATA;
          if (sub_naws && sub_count == NAWS_LEN) begin
            emit              = 1'b1;
            res.kind          = KIND_WINSZ;
            res.value_byte    = TN_NAWS;
            res.window_width  = {sub_bytes[0], sub_bytes[1]};
            res.window_height = {sub_bytes[2], sub_bytes[3]};
          end
        end else begin
          sub_wr = (sub_count < SUB_SLOTS);
          if (sub_count < SUB_SAT) begin
            sub_count_next = sub_count + 3'd1;
          end
        end
      end
      default: begin
        if (in_item.cls == CLS_IAC) begin
          phase_next = PH_IAC;
        end else begin
          phase_next = PH_DATA;
          emit       = 1'b1;
          res.kind   = KIND_DATA;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      pending_verb <= VERB_DO;
      sub_naws     <= 1'b0;
      sub_count    <= '0;
    end else if (in_take) begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
      sub_naws     <= sub_naws_next;
      sub_count    <= sub_count_next;
    end
  end

  // payload bytes of the subnegotiation, no reset
  always_ff @(posedge clk) begin
    if (in_take && sub_wr) begin
      sub_bytes[sub_count[1:0]] <= in_item.data;
    end
  end

`ifndef NO_ASSERTIONS
  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    res_push |-> in_take && !res_full)
    else $error("result pushed without a consumed byte");

  a_sbopt_clears_count: assert property (@(posedge clk) disable iff (rst)
    in_take && phase == PH_SBOPT |=> sub_count == 3'd0 && phase == PH_SBDATA)
    else $error("subnegotiation count not cleared after option byte");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !in_take |=> $stable(sub_count) && $stable(phase))
    else $error("parser state moved without a consumed byte");

  a_winsz_only_naws: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind == KIND_WINSZ |-> sub_naws && sub_count == NAWS_LEN)
    else $error("window size result outside a complete NAWS block");
`endif

endmodule

`default_nettype wire

// File: rtl/core/telnet_receive_deframer.sv
// ----------------------------------------------------------------------------
// telnet_receive_deframer
// Strips telnet IAC sequences from a received byte stream and reports
// data bytes, option requests, commands and window size updates.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  input   | in  | push / full          | rx_byte
//  result  | out | pop / empty          | kind, value_byte, verb,
//          |     |                      | window_width, window_height
//
//  Throughput is one byte per cycle while the result queue has room: the
//  mid queue takes a byte every cycle and the single-step parser state
//  machine consumes one per cycle, so the limit is the parser; a byte
//  with a result waits while the result queue is full. A byte's result
//  reaches the result ports once the parser takes it from the mid queue
//  and pushes it into the result queue, which falls through.
//  Synchronous active-high rst empties both queues and returns the parser to
//  the data phase; no clearing pass is needed.
//  A stall on pop backs up the result queue, then the mid queue, then raises
//  full; a byte that gives no result is still consumed while the result
//  queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_receive_deframer #(
  parameter int MidDepth = tnrd_pkg::MID_DEPTH_DEF,
  parameter int OutDepth = tnrd_pkg::OUT_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  // input queue side
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  rx_byte,
  // result queue side
  input  wire         pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [7:0]  value_byte,
  output logic [1:0]  verb,
  output logic [15:0] window_width,
  output logic [15:0] window_height
);

  import tnrd_pkg::*;

  item_t   front_item;   // classified byte from the front end
  item_t   mid_item;     // head of the mid queue
  logic    mid_empty;
  logic    take;         // parser consumes the head byte
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  // Front: tag each byte on its way into the mid queue
  tnrd_front u_front (
    .rx_byte (rx_byte),
    .item    (front_item)
  );

  // Mid queue decouples classification from parsing
  tnrd_fifo #(
    .Width (ITEM_W),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // Back: telnet state machine
  tnrd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mid_empty),
    .in_item  (mid_item),
    .in_take  (take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue holds finished transfers until popped
  tnrd_fifo #(
    .Width (RESULT_W),
    .Depth (OutDepth)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign kind          = res_out.kind;
  assign value_byte    = res_out.value_byte;
  assign verb          = res_out.verb;
  assign window_width  = res_out.window_width;
  assign window_height = res_out.window_height;

endmodule

`default_nettype wire
